// ===== rtl/assert_macros.svh =====
// Concurrent assertion helpers clocked on aclk, off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

`define ASSERT_NEVER(label, expr, msg) \
    `ASSERT_CLK(label, !(expr), msg)

`endif

// ===== rtl/pcr_pkg.sv =====
package pcr_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int FIELD_W        = 32;
    localparam int COUNT_W        = 31;
    localparam int TOTAL_W        = 32;
    localparam int IN_W           = 64;
    localparam int OUT_W          = 64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RANGE,
        S_SQ,
        S_DIV,
        S_REM,
        S_NEXT,
        S_EMIT
    } step_t;

    typedef enum logic [2:0] {
        C_IN_VALID,
        C_V_GT_HI,
        C_SQ_GT_V,
        C_DIV_DONE,
        C_REM_ZERO,
        C_V_EQ_HI,
        C_OUT_FREE
    } cond_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT_D,
        OP_COUNT,
        OP_DIV_START,
        OP_ADV_D,
        OP_ADV_V,
        OP_EMIT
    } op_t;

    typedef struct packed {
        cond_t cond;
        op_t   op_hit;
        step_t next_hit;
        op_t   op_miss;
        step_t next_miss;
    } ucode_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic ucode_t ucode_rom(step_t pc);
        ucode_t w;
        case (pc)
            S_IDLE:  w = '{C_IN_VALID, OP_LOAD,  S_RANGE, OP_NONE,      S_IDLE};
            S_RANGE: w = '{C_V_GT_HI,  OP_NONE,  S_EMIT,  OP_INIT_D,    S_SQ};
            S_SQ:    w = '{C_SQ_GT_V,  OP_COUNT, S_NEXT,  OP_DIV_START, S_DIV};
            S_DIV:   w = '{C_DIV_DONE, OP_NONE,  S_REM,   OP_NONE,      S_DIV};
            S_REM:   w = '{C_REM_ZERO, OP_NONE,  S_NEXT,  OP_ADV_D,     S_SQ};
            S_NEXT:  w = '{C_V_EQ_HI,  OP_NONE,  S_EMIT,  OP_ADV_V,     S_RANGE};
            S_EMIT:  w = '{C_OUT_FREE, OP_EMIT,  S_IDLE,  OP_NONE,      S_EMIT};
            default: w = '{C_IN_VALID, OP_NONE,  S_IDLE,  OP_NONE,      S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/pcr_div.sv =====
module pcr_div #(
    parameter int VALUE_BITS = pcr_pkg::VALUE_BITS_DEF,
    parameter int DIV_W      = VALUE_BITS / 2 + 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [DIV_W-1:0]      divisor,
    output logic [DIV_W-1:0]      rem,
    output pcr_pkg::div_stat_t    stat
);

    localparam int CW = $clog2(VALUE_BITS + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CW-1:0]         cnt_reg;
    logic [VALUE_BITS-1:0] quo_reg;
    logic [DIV_W-1:0]      rem_reg;
    logic [DIV_W-1:0]      dsr_reg;

    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             fits;
    logic [DIV_W-1:0] rem_step;

    always_comb begin
        trial    = {rem_reg, quo_reg[VALUE_BITS-1]};
        diff     = trial - {1'b0, dsr_reg};
        fits     = trial >= {1'b0, dsr_reg};
        rem_step = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (busy_reg) begin
                rem_reg <= rem_step;
                quo_reg <= {quo_reg[VALUE_BITS-2:0], 1'b0};
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end else if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(VALUE_BITS);
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
            end
        end
    end

    assign rem  = rem_reg;
    assign stat = '{busy: busy_reg, done: done_reg};

endmodule

// ===== rtl/prime_count_in_range_top.sv =====
// Per item: load the bounds; for each value, try trial divisors from 2 while divisor squared
// is not above the value, each on the bit-serial remainder unit; count a prime; then emit.
// Throughput: one item at a time; the bit-serial remainder unit sets the pace.
// The next item is taken while the previous result waits on the output register.
// Reset (aresetn low, synchronous): sequencer to idle, running total to zero,
// output valid cleared.
`include "assert_macros.svh"

module prime_count_in_range_top #(
    parameter int VALUE_BITS = pcr_pkg::VALUE_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // low_bound [31:0], high_bound [63:32]
    input  logic [pcr_pkg::IN_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // range_count [30:0], running_total [62:31], zero [63]
    output logic [pcr_pkg::OUT_W-1:0]  m_tdata
);

    localparam int DW  = VALUE_BITS / 2 + 1;
    localparam int SQW = VALUE_BITS + 1;
    localparam int CNW = pcr_pkg::COUNT_W;
    localparam int TTW = pcr_pkg::TOTAL_W;
    localparam int FW  = pcr_pkg::FIELD_W;

    pcr_pkg::step_t     pc_reg;
    pcr_pkg::step_t     pc_next;
    pcr_pkg::ucode_t    uw;
    pcr_pkg::op_t       op;
    logic               hit;

    logic [VALUE_BITS-1:0] v_reg;
    logic [VALUE_BITS-1:0] hi_reg;
    logic [DW-1:0]         d_reg;
    logic [SQW-1:0]        sq_reg;
    logic [CNW-1:0]        count_reg;
    logic [TTW-1:0]        total_reg;
    logic                  out_valid_reg;
    logic [CNW-1:0]        out_count_reg;
    logic [TTW-1:0]        out_total_reg;

    logic [VALUE_BITS-1:0] low_in;
    logic [VALUE_BITS-1:0] high_in;
    logic                  low_small;
    logic                  v_gt_hi;
    logic                  sq_gt_v;
    logic                  out_free;
    logic [TTW:0]          sum;
    logic [TTW-1:0]        total_sat;

    logic                  div_start;
    logic [DW-1:0]         div_rem;
    pcr_pkg::div_stat_t    div_stat;

    pcr_div #(
        .VALUE_BITS (VALUE_BITS),
        .DIV_W      (DW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (v_reg),
        .divisor  (d_reg),
        .rem      (div_rem),
        .stat     (div_stat)
    );

    always_comb begin
        low_in    = s_tdata[VALUE_BITS-1:0];
        high_in   = s_tdata[FW+VALUE_BITS-1:FW];
        low_small = low_in[VALUE_BITS-1] || (low_in[VALUE_BITS-2:1] == '0);
        v_gt_hi   = $signed({1'b0, v_reg}) > $signed({hi_reg[VALUE_BITS-1], hi_reg});
        sq_gt_v   = sq_reg > {1'b0, v_reg};
        out_free  = !out_valid_reg || m_tready;
        sum       = {1'b0, total_reg} + (TTW + 1)'(count_reg);
        total_sat = sum[TTW] ? '1 : sum[TTW-1:0];
    end

    always_comb begin
        uw = pcr_pkg::ucode_rom(pc_reg);
        case (uw.cond)
            pcr_pkg::C_IN_VALID: hit = s_tvalid;
            pcr_pkg::C_V_GT_HI:  hit = v_gt_hi;
            pcr_pkg::C_SQ_GT_V:  hit = sq_gt_v;
            pcr_pkg::C_DIV_DONE: hit = div_stat.done;
            pcr_pkg::C_REM_ZERO: hit = (div_rem == '0);
            pcr_pkg::C_V_EQ_HI:  hit = (v_reg == hi_reg);
            pcr_pkg::C_OUT_FREE: hit = out_free;
            default:             hit = 1'b0;
        endcase
        op      = hit ? uw.op_hit : uw.op_miss;
        pc_next = hit ? uw.next_hit : uw.next_miss;
    end

    assign div_start = (op == pcr_pkg::OP_DIV_START);
    assign s_tready  = (pc_reg == pcr_pkg::S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= pcr_pkg::S_IDLE;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pc_reg <= pc_next;
            if (out_valid_reg && m_tready && op != pcr_pkg::OP_EMIT) begin
                out_valid_reg <= 1'b0;
            end
            unique case (op)
                pcr_pkg::OP_NONE: begin
                end
                pcr_pkg::OP_LOAD: begin
                    v_reg     <= low_small ? VALUE_BITS'(2) : low_in;
                    hi_reg    <= high_in;
                    count_reg <= '0;
                end
                pcr_pkg::OP_INIT_D: begin
                    d_reg  <= DW'(2);
                    sq_reg <= SQW'(4);
                end
                pcr_pkg::OP_COUNT: begin
                    count_reg <= count_reg + CNW'(1);
                end
                pcr_pkg::OP_DIV_START: begin
                end
                pcr_pkg::OP_ADV_D: begin
                    d_reg  <= d_reg + DW'(1);
                    sq_reg <= sq_reg + SQW'({d_reg, 1'b1});
                end
                pcr_pkg::OP_ADV_V: begin
                    v_reg <= v_reg + VALUE_BITS'(1);
                end
                pcr_pkg::OP_EMIT: begin
                    total_reg     <= total_sat;
                    out_total_reg <= total_sat;
                    out_count_reg <= count_reg;
                    out_valid_reg <= 1'b1;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_total_reg, out_count_reg};

    `ASSERT_NEVER(a_start_while_busy, div_start && div_stat.busy, "divider restarted while busy")
    `ASSERT_CLK(a_done_after_busy, div_stat.done |-> $past(div_stat.busy), "done without busy")
    `ASSERT_CLK(a_total_covers_count, m_tvalid |-> (out_total_reg >= TTW'(out_count_reg)), "total below count")

endmodule

// ===== tb/prime_count_in_range_top_test.sv =====
module prime_count_in_range_top_test;

    typedef struct {
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        bit                 known;
        int unsigned        count;
    } probe_t;

    typedef struct {
        logic [pcr_pkg::COUNT_W-1:0] count;
        logic [pcr_pkg::TOTAL_W-1:0] total;
    } tally_t;

    logic                       aclk     = 1'b0;
    logic                       aresetn  = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [pcr_pkg::IN_W-1:0]   s_tdata  = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [pcr_pkg::OUT_W-1:0]  m_tdata;

    tally_t                      pending_tallies[$];
    logic [pcr_pkg::TOTAL_W-1:0] primes_so_far = '0;
    int unsigned                 mismatches    = 0;
    bit                          calm          = 1'b0;
    int unsigned                 stall_left    = 0;

    probe_t probes [22] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 0},
        '{32'h0000_0001, 32'h0000_0001, 1'b1, 0},
        '{32'h0000_0002, 32'h0000_0002, 1'b1, 1},
        '{32'h0000_0003, 32'h0000_0003, 1'b1, 1},
        '{32'h8000_0000, 32'h8000_0000, 1'b1, 0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 0},
        '{32'h8000_0000, 32'h0000_0001, 1'b1, 0},
        '{32'h8000_0000, 32'h0000_000A, 1'b1, 4},
        '{32'h0000_000A, 32'h0000_0002, 1'b1, 0},
        '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 0},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFE, 1'b1, 0},
        '{32'h7FFF_FFFC, 32'h7FFF_FFFE, 1'b1, 0},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1},
        '{32'hFFFF_FFFB, 32'h0000_001E, 1'b1, 10},
        '{32'h0000_0004, 32'h0000_0004, 1'b1, 0},
        '{32'h0000_0019, 32'h0000_0019, 1'b1, 0},
        '{32'h0000_0061, 32'h0000_0061, 1'b1, 1},
        '{32'h0000_0064, 32'h0000_0064, 1'b1, 0},
        '{32'h0000_0001, 32'h0000_0064, 1'b1, 25},
        '{32'h0000_FFF1, 32'h0000_FFF1, 1'b1, 1},
        '{32'h0000_03E8, 32'h0000_03F7, 1'b0, 0},
        '{32'h0001_0000, 32'h0001_0003, 1'b0, 0}
    };

    prime_count_in_range_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic logic [pcr_pkg::COUNT_W-1:0] primes_between(
        logic signed [31:0] lo, logic signed [31:0] hi);
        longint first;
        longint last;
        longint v;
        longint d;
        bit     no_factor;
        int unsigned n;
        first = lo;
        last  = hi;
        n     = 0;
        if (first < 2) begin
            first = 2;
        end
        for (v = first; v <= last; v++) begin
            no_factor = 1'b1;
            for (d = 2; no_factor && d * d <= v; d++) begin
                if (v % d == 0) begin
                    no_factor = 1'b0;
                end
            end
            if (no_factor) begin
                n++;
            end
        end
        return n[pcr_pkg::COUNT_W-1:0];
    endfunction

    task automatic send_bounds(input logic signed [31:0] lo, input logic signed [31:0] hi,
                               input bit known, input int unsigned typed_count);
        int unsigned                 gap;
        logic [pcr_pkg::COUNT_W-1:0] cnt;
        longint                      sum;
        tally_t                      t;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {hi, lo};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        cnt = known ? typed_count[pcr_pkg::COUNT_W-1:0] : primes_between(lo, hi);
        sum = longint'(primes_so_far) + longint'(cnt);
        primes_so_far = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        t.count = cnt;
        t.total = primes_so_far;
        pending_tallies = {pending_tallies, t};
    endtask

    task automatic drain_tallies();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_tallies.size() != 0);
    endtask

    // check each result transfer and stall the result side in bursts
    always @(posedge aclk) begin
        tally_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_tallies.size() == 0) begin
                    $error("unexpected result transfer: %h", m_tdata);
                    mismatches++;
                end else begin
                    want = pending_tallies.pop_front();
                    if (m_tdata[30:0] !== want.count) begin
                        $error("range_count: expected %0d, got %0d", want.count, m_tdata[30:0]);
                        mismatches++;
                    end
                    if (m_tdata[62:31] !== want.total) begin
                        $error("running_total: expected %0d, got %0d",
                               want.total, m_tdata[62:31]);
                        mismatches++;
                    end
                    if (m_tdata[63] !== 1'b0) begin
                        $error("zero: expected 0, got %b", m_tdata[63]);
                        mismatches++;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 6);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [31:0] swap;
        int unsigned        kind;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (probes[i]) begin
            send_bounds(probes[i].lo, probes[i].hi, probes[i].known, probes[i].count);
        end
        drain_tallies();

        for (int i = 0; i < 100; i++) begin
            calm = (i >= 80);
            if (i == 50) begin
                drain_tallies();
            end
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                lo = $signed($urandom_range(0, 1000)) - 20;
                hi = lo + $signed($urandom_range(0, 15));
            end else if (kind == 6) begin
                lo = {1'b1, 31'($urandom)};
                hi = $urandom_range(0, 40);
            end else if (kind == 7) begin
                lo = $urandom;
                hi = $urandom;
                if (lo < hi) begin
                    swap = lo;
                    lo   = hi;
                    hi   = swap;
                end
                if (lo == hi) begin
                    lo = 32'h7FFF_FFFF;
                    hi = 32'h8000_0000;
                end
            end else if (kind == 8) begin
                lo = {1'b1, 31'($urandom)};
                hi = {1'b1, 31'($urandom)};
            end else begin
                lo = $urandom_range(65536, 262144);
                hi = lo + $signed($urandom_range(0, 3));
            end
            send_bounds(lo, hi, 1'b0, 0);
        end
        drain_tallies();
        repeat (50) @(posedge aclk);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #(64'd360_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pcr_pkg.sv
rtl/pcr_div.sv
rtl/prime_count_in_range_top.sv
tb/prime_count_in_range_top_test.sv
